// ===== src/ultrasonic_range_controller_macros.svh =====
// Assertion macros for the ultrasonic range controller.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH
`define ULTRASONIC_RANGE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define URC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("urc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define URC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("urc: next-cycle check failed");

`endif

// ===== src/urc_pkg.sv =====
// Shared types, codes and helpers for the ultrasonic range controller.
// No dependencies; imported by urc_core and the top level.
`default_nettype none

package urc_pkg;

	// Default timing, in microsecond ticks
	localparam int TICKS_PER_MS_DEF    = 1000;
	localparam int TRIG_LOW_TICKS_DEF  = 2;
	localparam int TRIG_HIGH_TICKS_DEF = 10;

	// Phase codes
	localparam logic [2:0] PH_OFF     = 3'd0;
	localparam logic [2:0] PH_TRIG    = 3'd1;
	localparam logic [2:0] PH_WAIT    = 3'd2;
	localparam logic [2:0] PH_READY   = 3'd3;
	localparam logic [2:0] PH_BETWEEN = 3'd4;

	// Configuration register indexes
	localparam logic CFG_ENABLE   = 1'b0;
	localparam logic CFG_INTERVAL = 1'b1;

	localparam logic [15:0] INTERVAL_RST = 16'd10;

	// width*10/58 = floor(width * ceil(5*2^24/29) / 2^24), exact for 16-bit widths
	localparam logic [21:0] DIST_MUL   = 22'd2892624;
	localparam int          DIST_SHIFT = 24;

	typedef struct packed {
		logic        enable;
		logic [15:0] interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic        reading_done;
		logic [15:0] echo_width_us;
		logic [13:0] distance_mm;
		logic        trigger_level;
	} result_t;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [13:0] dist_of(input logic [15:0] w);
		logic [37:0] p;
		p = {22'd0, w} * {16'd0, DIST_MUL};
		return p[DIST_SHIFT+13:DIST_SHIFT];
	endfunction

endpackage

`default_nettype wire

// ===== src/ultrasonic_range_controller.sv =====
// Top level of the ultrasonic range controller: stream ports, config registers,
// input register and result register around urc_core. Depends on urc_pkg, urc_core.
//
//   channel  | direction | word contents
//   s_*      | in        | one microsecond tick: echo_level
//   m_*      | out       | one result per tick: trigger, distance, width, done, phase
//   cfg_*    | in        | register write: 0 enable, 1 interval_ms
//
// One word per cycle sustained while the output is ready; each tick's result passes
// through the input register, then the result register fed by the sequencer and the
// constant-reciprocal distance multiply. A stalled output holds its word while
// one more tick waits in the input register. Reset is asynchronous, active low,
// and clears all sequencer state; no clearing pass is needed.
`default_nettype none

module ultrasonic_range_controller import urc_pkg::*; #(
	parameter int TICKS_PER_MS    = TICKS_PER_MS_DEF,
	parameter int TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
	parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] echo_level, [7:1] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [0] trigger_level, [14:1] distance_mm,
	                                    // [30:15] echo_width_us, [31] reading_done,
	                                    // [34:32] phase, [39:35] zero
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [15:0] cfg_wdata
);

`include "ultrasonic_range_controller_macros.svh"

	cfg_t    cfg_q;
	logic    valid_s1, echo_s1;
	logic    valid_s2;
	result_t res_s2, res_next;
	logic    adv;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= 1'b0;
			cfg_q.interval_ms <= INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ENABLE:   cfg_q.enable      <= cfg_wdata[0];
				CFG_INTERVAL: cfg_q.interval_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Pipeline control: a tick moves on when the result register is empty or being read
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			echo_s1 <= s_tdata[0];
	end

	urc_core #(
		.TICKS_PER_MS    (TICKS_PER_MS),
		.TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
		.TRIG_HIGH_TICKS (TRIG_HIGH_TICKS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.echo   (echo_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res_next;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2};

	// Checks
	`URC_ASSERT_NOW(a_stall_only_when_full, !s_tready, valid_s1 && valid_s2 && !m_tready)
	`URC_ASSERT_NOW(a_trig_in_trig_phase, valid_s2 && res_s2.trigger_level,
		res_s2.phase == PH_TRIG)
	`URC_ASSERT_NOW(a_done_phase, valid_s2 && res_s2.reading_done,
		res_s2.phase == PH_READY || res_s2.phase == PH_TRIG)
	`URC_ASSERT_NEXT(a_adv_fills_output, adv, valid_s2)

endmodule

`default_nettype wire

// ===== src/urc_core.sv =====
// Ranging sequencer: phase state, trigger timing, echo measurement, interval wait.
// Depends on urc_pkg. State advances once per accepted tick (step).
`default_nettype none

module urc_core import urc_pkg::*; #(
	parameter int TICKS_PER_MS    = TICKS_PER_MS_DEF,
	parameter int TRIG_LOW_TICKS  = TRIG_LOW_TICKS_DEF,
	parameter int TRIG_HIGH_TICKS = TRIG_HIGH_TICKS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire logic    echo,
	input  wire cfg_t    cfg,
	output result_t      res
);

	localparam int PW = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
	localparam int TT = TRIG_LOW_TICKS + TRIG_HIGH_TICKS;
	localparam int TW = $clog2(TT);
	localparam logic [PW:0]   PRESC_END = (PW+1)'(TICKS_PER_MS);
	localparam logic [TW:0]   TRIG_END  = (TW+1)'(TT);
	localparam logic [TW-1:0] TRIG_LOW  = TW'(TRIG_LOW_TICKS);

	logic [2:0]    phase_q,     phase_d;
	logic [TW-1:0] trig_q,      trig_d;
	logic [15:0]   echo_cnt_q,  echo_cnt_d;
	logic [15:0]   width_q,     width_d;
	logic [PW-1:0] presc_q,     presc_d;
	logic [15:0]   elapsed_q,   elapsed_d;
	logic          echo_prev_q;

	logic [TW:0]   trig_inc;
	logic [PW:0]   presc_inc;
	logic          rise, fall, done, active;

	// Next-state logic for one tick
	always_comb begin
		phase_d    = phase_q;
		trig_d     = trig_q;
		echo_cnt_d = echo_cnt_q;
		width_d    = width_q;
		presc_d    = presc_q;
		elapsed_d  = elapsed_q;
		done       = 1'b0;
		trig_inc   = {1'b0, trig_q} + {{TW{1'b0}}, 1'b1};
		presc_inc  = {1'b0, presc_q} + {{PW{1'b0}}, 1'b1};
		rise       = echo && !echo_prev_q;
		fall       = !echo && echo_prev_q;
		active     = (phase_q >= PH_TRIG) && (phase_q <= PH_BETWEEN);

		unique case (phase_q)
			PH_TRIG: begin
				if (trig_inc >= TRIG_END) begin
					trig_d  = '0;
					phase_d = PH_WAIT;
				end else begin
					trig_d = trig_inc[TW-1:0];
				end
			end
			PH_WAIT: begin
			end
			PH_READY: begin
				presc_d   = '0;
				elapsed_d = '0;
				phase_d   = PH_BETWEEN;
			end
			PH_BETWEEN: begin
				if (presc_inc >= PRESC_END) begin
					presc_d   = '0;
					elapsed_d = sat_inc16(elapsed_q);
				end else begin
					presc_d = presc_inc[PW-1:0];
				end
				if (elapsed_d >= cfg.interval_ms) begin
					trig_d  = '0;
					phase_d = PH_TRIG;
				end
			end
			default: begin
				// off, and any stray code
				phase_d = PH_OFF;
				if (cfg.enable) begin
					trig_d  = '0;
					phase_d = PH_TRIG;
				end
			end
		endcase

		// Echo measurement runs in every phase but off and any stray code
		if (active) begin
			echo_cnt_d = rise ? 16'd0 : sat_inc16(echo_cnt_q);
			if (fall) begin
				width_d = echo_cnt_d;
				done    = 1'b1;
				if (phase_d != PH_TRIG)
					phase_d = PH_READY;
			end
		end
	end

	// Result word, taken after this tick's update
	always_comb begin
		res.trigger_level = (phase_d == PH_TRIG) && (trig_d >= TRIG_LOW);
		res.distance_mm   = dist_of(width_d);
		res.echo_width_us = width_d;
		res.reading_done  = done;
		res.phase         = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OFF;
			trig_q      <= '0;
			echo_cnt_q  <= '0;
			width_q     <= '0;
			presc_q     <= '0;
			elapsed_q   <= '0;
			echo_prev_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			trig_q      <= trig_d;
			echo_cnt_q  <= echo_cnt_d;
			width_q     <= width_d;
			presc_q     <= presc_d;
			elapsed_q   <= elapsed_d;
			echo_prev_q <= echo;
		end
	end

endmodule

`default_nettype wire
